### design/dqu_pkg.sv
// Shared types and codes for the double-ended queue unit.
`default_nettype none

package dqu_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int WORD_BITS_DEF = 32;

    localparam int CMD_BITS    = 3;
    localparam int STATUS_BITS = 2;
    localparam int DATA_BITS   = 32;
    localparam int FILL_BITS   = 5;

    localparam logic [CMD_BITS-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_PUSH_REAR  = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_POP_REAR   = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_PEEK       = 3'd4;

    localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [CMD_BITS-1:0]         command;
        logic signed [DATA_BITS-1:0] data_in;
    } dqu_in_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0]      status;
        logic signed [DATA_BITS-1:0] removed_value;
        logic signed [DATA_BITS-1:0] front_value;
        logic signed [DATA_BITS-1:0] rear_value;
        logic [FILL_BITS-1:0]        fill_level;
        logic                        is_empty;
    } dqu_out_t;

endpackage

`default_nettype wire

### design/dqu_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module dqu_ram #(
    parameter int WIDTH = dqu_pkg::WORD_BITS_DEF,
    parameter int DEPTH = dqu_pkg::DEPTH_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire logic [WIDTH-1:0]           wr_data,
    input  wire logic                       rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic      [WIDTH-1:0]           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### design/double_ended_queue_unit.sv
// Bounded double-ended queue of signed words in a circular RAM.
// A push, a peek, a refused command or a pop that empties the deque shows
//   its result in the cycle after acceptance; one per cycle with m_ready high.
// A pop that leaves words behind passes through the read state: the new end
//   word returns on the single RAM read port in the cycle after its address.
// Reset (aresetn low, synchronous) clears state, head, count and output valid;
//   RAM contents stay undefined until written and need no clearing pass.
`default_nettype none

module double_ended_queue_unit #(
    parameter int DEPTH     = dqu_pkg::DEPTH_DEF,
    parameter int WORD_BITS = dqu_pkg::WORD_BITS_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire dqu_pkg::dqu_in_t s_payload,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output dqu_pkg::dqu_out_t     m_payload
);

    import dqu_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int SW = IW + 1;
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    typedef logic [WORD_BITS-1:0] word_t;

    logic            state_reg,   state_next;
    logic [IW-1:0]   head_reg,    head_next;
    logic [CW-1:0]   count_reg,   count_next;
    word_t           front_reg,   front_next;
    word_t           rear_reg,    rear_next;
    word_t           removed_reg, removed_next;
    logic            side_reg,    side_next;
    logic            m_valid_reg, m_valid_next;
    dqu_out_t        m_payload_reg, m_payload_next;

    logic            wr_en;
    logic [IW-1:0]   wr_addr;
    word_t           wr_data;
    logic            rd_en;
    logic [IW-1:0]   rd_addr;
    word_t           rd_data;

    logic            accept;
    logic            is_full;
    logic            is_empty_now;
    logic            need_read;
    logic [STATUS_BITS-1:0] status;
    word_t           removed;
    word_t           word_in;
    logic [SW-1:0]   head_ext;
    logic [SW-1:0]   count_ext;

    function automatic logic [IW-1:0] wrap_idx(input logic [SW-1:0] s);
        logic [SW-1:0] d;
        begin
            d = (s >= SW'(DEPTH)) ? s - SW'(DEPTH) : s;
            return d[IW-1:0];
        end
    endfunction

    function automatic logic [DATA_BITS-1:0] to_out(input word_t w);
        logic [WORD_BITS+DATA_BITS-1:0] ext;
        begin
            ext = {{DATA_BITS{w[WORD_BITS-1]}}, w};
            return ext[DATA_BITS-1:0];
        end
    endfunction

    function automatic dqu_out_t build_out(
        input logic [STATUS_BITS-1:0] st,
        input word_t                  rem,
        input word_t                  fr,
        input word_t                  rr,
        input logic [CW-1:0]          cnt
    );
        dqu_out_t                 o;
        logic [CW+FILL_BITS-1:0]  cnt_ext;
        begin
            cnt_ext         = {{FILL_BITS{1'b0}}, cnt};
            o.status        = st;
            o.removed_value = to_out(rem);
            o.front_value   = (cnt == '0) ? '1 : to_out(fr);
            o.rear_value    = (cnt == '0) ? '1 : to_out(rr);
            o.fill_level    = cnt_ext[FILL_BITS-1:0];
            o.is_empty      = (cnt == '0);
            return o;
        end
    endfunction

    logic [WORD_BITS+DATA_BITS-1:0] data_ext;

    assign data_ext     = {{WORD_BITS{s_payload.data_in[DATA_BITS-1]}}, s_payload.data_in};
    assign word_in      = data_ext[WORD_BITS-1:0];
    assign head_ext     = {1'b0, head_reg};
    assign count_ext    = SW'(count_reg);
    assign is_full      = (count_reg == CW'(DEPTH));
    assign is_empty_now = (count_reg == '0);

    assign s_ready   = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        front_next     = front_reg;
        rear_next      = rear_reg;
        removed_next   = removed_reg;
        side_next      = side_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_payload_next = m_payload_reg;
        wr_en          = 1'b0;
        wr_addr        = head_reg;
        wr_data        = word_in;
        rd_en          = 1'b0;
        rd_addr        = head_reg;
        status         = STATUS_OK;
        removed        = '0;
        need_read      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_payload.command)
                        CMD_PUSH_FRONT: begin
                            if (is_full) begin
                                status = STATUS_FULL;
                            end else begin
                                head_next  = (head_reg == '0) ? IW'(DEPTH - 1)
                                                              : head_reg - IW'(1);
                                count_next = count_reg + CW'(1);
                                wr_en      = 1'b1;
                                wr_addr    = head_next;
                                front_next = word_in;
                                if (is_empty_now) begin
                                    rear_next = word_in;
                                end
                            end
                        end
                        CMD_PUSH_REAR: begin
                            if (is_full) begin
                                status = STATUS_FULL;
                            end else begin
                                count_next = count_reg + CW'(1);
                                wr_en      = 1'b1;
                                wr_addr    = wrap_idx(head_ext + count_ext);
                                rear_next  = word_in;
                                if (is_empty_now) begin
                                    front_next = word_in;
                                end
                            end
                        end
                        CMD_POP_FRONT: begin
                            if (is_empty_now) begin
                                status = STATUS_EMPTY;
                            end else begin
                                removed    = front_reg;
                                head_next  = wrap_idx(head_ext + SW'(1));
                                count_next = count_reg - CW'(1);
                                if (count_reg > CW'(1)) begin
                                    need_read = 1'b1;
                                    rd_en     = 1'b1;
                                    rd_addr   = head_next;
                                    side_next = 1'b0;
                                end
                            end
                        end
                        CMD_POP_REAR: begin
                            if (is_empty_now) begin
                                status = STATUS_EMPTY;
                            end else begin
                                removed    = rear_reg;
                                count_next = count_reg - CW'(1);
                                if (count_reg > CW'(1)) begin
                                    need_read = 1'b1;
                                    rd_en     = 1'b1;
                                    rd_addr   = wrap_idx(head_ext + count_ext - SW'(2));
                                    side_next = 1'b1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (need_read) begin
                        state_next   = ST_READ;
                        removed_next = removed;
                    end else begin
                        m_valid_next   = 1'b1;
                        m_payload_next = build_out(status, removed, front_next,
                                                   rear_next, count_next);
                    end
                end
            end
            ST_READ: begin
                if (!m_valid_reg || m_ready) begin
                    if (side_reg) begin
                        rear_next = rd_data;
                    end else begin
                        front_next = rd_data;
                    end
                    m_valid_next   = 1'b1;
                    m_payload_next = build_out(STATUS_OK, removed_reg, front_next,
                                               rear_next, count_reg);
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        front_reg     <= front_next;
        rear_reg      <= rear_next;
        removed_reg   <= removed_next;
        side_reg      <= side_next;
        m_payload_reg <= m_payload_next;
    end

    dqu_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("fill count above depth");

    a_head_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg < IW'(DEPTH - 1) || head_reg == IW'(DEPTH - 1))
        else $error("head index out of range");

    a_no_rw_same_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr_en && rd_en))
        else $error("RAM written and read in one cycle");

    a_read_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_READ |-> !s_ready)
        else $error("input accepted during pending RAM read");

    a_empty_pop_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && count_reg == '0 &&
         (s_payload.command == CMD_POP_FRONT || s_payload.command == CMD_POP_REAR))
        |=> (count_reg == '0 && m_valid_reg && m_payload_reg.status == STATUS_EMPTY))
        else $error("pop on empty deque changed state");

endmodule

`default_nettype wire
